// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scio assertion failed");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scio assertion failed");

`endif

// ===== sv/scio_pkg.sv =====
// shared types, constants and text tables of the serial command and i/o controller
// no dependencies
`timescale 1ns / 1ps

package scio_pkg;

	// receive store
	localparam int RX_DEPTH = 16;
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int RX_CW    = $clog2(RX_DEPTH + 1);

	// averaging ring
	localparam int AVG_DEPTH = 8;
	localparam int AVG_AW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int AVG_SHIFT = 3;
	localparam int ADC_W     = 10;
	localparam int TOTAL_W   = ADC_W + $clog2(AVG_DEPTH);

	// response text lengths
	localparam int VER_LEN = 37;
	localparam int REP_LEN = 16;
	localparam int RESP_IW = $clog2(VER_LEN + 1);

	// request types
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_PARSE  = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	// characters
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_LBR       = 8'h5b;
	localparam logic [7:0] CH_RBR       = 8'h5d;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_ONE       = 8'h31;
	localparam logic [7:0] CH_SEVEN     = 8'h37;
	localparam logic [7:0] CH_HEX_ALPHA = 8'h37;
	localparam logic [7:0] CH_Q         = 8'h51;
	localparam logic [7:0] CH_B         = 8'h42;
	localparam logic [7:0] CH_R         = 8'h52;
	localparam logic [7:0] CH_T         = 8'h54;
	localparam logic [7:0] CH_H         = 8'h48;
	localparam logic [7:0] CH_L         = 8'h4c;
	localparam logic [7:0] CH_D         = 8'h44;
	localparam logic [7:0] CH_LC_C      = 8'h63;
	localparam logic [7:0] CH_ALL_ON    = 8'hff;
	localparam logic [7:0] CH_ALL_OFF   = 8'h00;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [7:0]       rx_byte;
		logic             adc_channel;
		logic [ADC_W-1:0] adc_value;
		logic [7:0]       port_pins;
	} scio_in_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic [7:0] discrete_outputs;
		logic       boot_request;
	} scio_out_t;

	typedef enum logic [1:0] {
		RESP_NONE = 2'b00,
		RESP_VER  = 2'b01,
		RESP_REP  = 2'b10
	} resp_kind_t;

	// receive store status toward the sequencer
	typedef struct packed {
		logic [RX_CW-1:0] count;
		logic [7:0]       hdr0;
		logic [7:0]       hdr1;
		logic [7:0]       hdr2;
	} rx_status_t;

	// sequencer to transmit stage
	typedef struct packed {
		logic       push;
		logic [7:0] ch;
		logic       finish;
	} tx_ctl_t;

	// transmit stage back to sequencer
	typedef struct packed {
		logic push_ok;
		logic finish_ok;
	} tx_status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] dx;
		dx = {4'h0, d};
		hex_char = (d < 4'd10) ? (CH_ZERO + dx) : (CH_HEX_ALPHA + dx);
	endfunction

	// version banner with trailing lf cr
	function automatic logic [7:0] version_char(input logic [RESP_IW-1:0] k);
		logic [7:0] c;
		case (k)
			6'd0:    c = 8'h5b;
			6'd1:    c = 8'h57;
			6'd2:    c = 8'h68;
			6'd3:    c = 8'h65;
			6'd4:    c = 8'h65;
			6'd5:    c = 8'h6c;
			6'd6:    c = 8'h20;
			6'd7:    c = 8'h53;
			6'd8:    c = 8'h65;
			6'd9:    c = 8'h6e;
			6'd10:   c = 8'h73;
			6'd11:   c = 8'h6f;
			6'd12:   c = 8'h72;
			6'd13:   c = 8'h20;
			6'd14:   c = 8'h76;
			6'd15:   c = 8'h33;
			6'd16:   c = 8'h2e;
			6'd17:   c = 8'h30;
			6'd18:   c = 8'h2e;
			6'd19:   c = 8'h30;
			6'd20:   c = 8'h20;
			6'd21:   c = 8'h31;
			6'd22:   c = 8'h30;
			6'd23:   c = 8'h37;
			6'd24:   c = 8'h49;
			6'd25:   c = 8'h20;
			6'd26:   c = 8'h32;
			6'd27:   c = 8'h30;
			6'd28:   c = 8'h31;
			6'd29:   c = 8'h35;
			6'd30:   c = 8'h30;
			6'd31:   c = 8'h39;
			6'd32:   c = 8'h30;
			6'd33:   c = 8'h33;
			6'd34:   c = 8'h5d;
			6'd35:   c = CH_LF;
			6'd36:   c = CH_CR;
			default: c = 8'h00;
		endcase
		version_char = c;
	endfunction

endpackage

// ===== sv/serial_command_io_controller.sv =====
// top level: request intake, parse sequencer and command decode
// depends on scio_pkg, scio_rx_buf, scio_ring, scio_tx_stage
`timescale 1ns / 1ps
//
//  channel   handshake                   payload      moves
//  item      item_valid / item_stall     item         one request in
//  result    result_valid / result_stall result       one character out
//
//  byte, channel 1 sample and unused requests leave intake free; a channel 0 sample
//  holds intake while the ring memory does its read-modify-write
//  a parse does a store read for each stored byte and a push for each echoed one,
//  then a push for each response character and a final flush; result stalls can hold
//  any push or the flush
//  reset clears the sequencer, counts, output levels and ring valid bits at once
//  no request is taken while a parse or a ring update is in progress

module serial_command_io_controller import scio_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  scio_in_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output scio_out_t result
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_ECHO_RD = 5'b00010,
		ST_ECHO_WR = 5'b00100,
		ST_RESP    = 5'b01000,
		ST_FLUSH   = 5'b10000
	} state_t;

	state_t             state_q;
	logic [RX_CW-1:0]   idx_q;
	logic [RX_CW-1:0]   echo_len_q;
	logic [RESP_IW-1:0] k_q;
	resp_kind_t         kind_q;
	logic               boot_q;
	logic [7:0]         levels_q;
	logic [7:0]         pins_q;

	// intake
	logic accept;
	logic byte_go, parse_go, sample_go;
	logic ring_busy;

	// store and ring
	rx_status_t         rx_st;
	logic [7:0]         rd_data;
	logic               rd_en;
	logic [TOTAL_W-1:0] ring_total;
	logic [ADC_W-1:0]   latest;

	// transmit
	tx_ctl_t    tx_ctl;
	tx_status_t tx_st;

	// decode
	logic         cmd_ok, has_arg, arg_bit_ok;
	logic [7:0]   cmd, arg, bit_mask;
	resp_kind_t   kind_d;
	logic         boot_d;
	logic [7:0]   levels_d;

	// response text
	logic [RESP_IW-1:0] resp_len;
	logic [7:0]         resp_ch;
	logic [7:0]         pins_rev;
	logic [TOTAL_W-1:0] avg_full;
	logic [15:0]        avg16;
	logic [15:0]        latest16;
	logic               echo_skip;

	// no intake while parsing or while the ring writes back
	assign item_stall = (state_q != ST_IDLE) || ring_busy;
	assign accept     = item_valid && !item_stall;
	assign byte_go    = accept && (item.req_type == REQ_BYTE);
	assign parse_go   = accept && (item.req_type == REQ_PARSE);
	assign sample_go  = accept && (item.req_type == REQ_SAMPLE);

	scio_rx_buf u_rx_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_go   (byte_go),
		.wr_byte (item.rx_byte),
		.clr     (parse_go),
		.rd_en   (rd_en),
		.rd_addr (idx_q[RX_AW-1:0]),
		.rd_data (rd_data),
		.status  (rx_st)
	);

	scio_ring u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_go   (sample_go),
		.adc_channel (item.adc_channel),
		.adc_value   (item.adc_value),
		.busy        (ring_busy),
		.total       (ring_total),
		.latest      (latest)
	);

	// command decode from the header bytes of the current message
	always_comb begin
		cmd        = rx_st.hdr1;
		arg        = rx_st.hdr2;
		cmd_ok     = (rx_st.count >= RX_CW'(2)) && (rx_st.hdr0 == CH_LBR);
		has_arg    = rx_st.count >= RX_CW'(3);
		arg_bit_ok = has_arg && (arg >= CH_ZERO) && (arg <= CH_SEVEN);
		// '0'..'7' carry the bit number in their low three bits
		bit_mask   = 8'h01 << arg[2:0];
		kind_d     = RESP_NONE;
		boot_d     = 1'b0;
		levels_d   = levels_q;
		if (cmd_ok) begin
			case (cmd)
				CH_Q: kind_d = RESP_VER;
				CH_B: boot_d = 1'b1;
				CH_R: kind_d = RESP_REP;
				CH_T: begin
					if (has_arg && arg == CH_ZERO) begin
						levels_d = CH_ALL_ON;
					end else if (has_arg && arg == CH_ONE) begin
						levels_d = CH_ALL_OFF;
					end
				end
				CH_H: begin
					if (arg_bit_ok) begin
						levels_d = levels_q | bit_mask;
					end
				end
				CH_L: begin
					if (arg_bit_ok) begin
						levels_d = levels_q & ~bit_mask;
					end
				end
				default: kind_d = RESP_NONE;
			endcase
		end
	end

	// report fields
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pins_rev[i] = pins_q[7 - i];
		end
		avg_full = ring_total >> AVG_SHIFT;
		avg16    = 16'(avg_full);
		latest16 = 16'(latest);
	end

	always_comb begin
		case (kind_q)
			RESP_VER: resp_len = RESP_IW'(VER_LEN);
			RESP_REP: resp_len = RESP_IW'(REP_LEN);
			default:  resp_len = '0;
		endcase
	end

	always_comb begin
		resp_ch = 8'h00;
		case (kind_q)
			RESP_VER: resp_ch = version_char(k_q);
			RESP_REP: begin
				case (k_q[3:0])
					4'd0:    resp_ch = CH_LBR;
					4'd1:    resp_ch = CH_D;
					4'd2:    resp_ch = hex_char(pins_rev[7:4]);
					4'd3:    resp_ch = hex_char(pins_rev[3:0]);
					4'd4:    resp_ch = hex_char(avg16[15:12]);
					4'd5:    resp_ch = hex_char(avg16[11:8]);
					4'd6:    resp_ch = hex_char(avg16[7:4]);
					4'd7:    resp_ch = hex_char(avg16[3:0]);
					4'd8:    resp_ch = hex_char(latest16[15:12]);
					4'd9:    resp_ch = hex_char(latest16[11:8]);
					4'd10:   resp_ch = hex_char(latest16[7:4]);
					4'd11:   resp_ch = hex_char(latest16[3:0]);
					4'd12:   resp_ch = CH_LC_C;
					4'd13:   resp_ch = CH_RBR;
					4'd14:   resp_ch = CH_LF;
					4'd15:   resp_ch = CH_CR;
					default: resp_ch = 8'h00;
				endcase
			end
			default: resp_ch = 8'h00;
		endcase
	end

	// echo drops cr and lf
	assign echo_skip = (rd_data == CH_CR) || (rd_data == CH_LF);
	assign rd_en     = (state_q == ST_ECHO_RD) && (idx_q != echo_len_q);

	always_comb begin
		tx_ctl.push   = 1'b0;
		tx_ctl.ch     = rd_data;
		tx_ctl.finish = 1'b0;
		case (state_q)
			ST_ECHO_WR: tx_ctl.push = !echo_skip;
			ST_RESP: begin
				tx_ctl.push = (k_q != resp_len);
				tx_ctl.ch   = resp_ch;
			end
			ST_FLUSH: tx_ctl.finish = 1'b1;
			default:  tx_ctl.push = 1'b0;
		endcase
	end

	// parse sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			echo_len_q <= '0;
			k_q        <= '0;
			kind_q     <= RESP_NONE;
			boot_q     <= 1'b0;
			levels_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (parse_go) begin
						// command acts at once; every result of the parse shows its effect
						echo_len_q <= rx_st.count;
						idx_q      <= '0;
						kind_q     <= kind_d;
						boot_q     <= boot_d;
						levels_q   <= levels_d;
						state_q    <= ST_ECHO_RD;
					end
				end
				ST_ECHO_RD: begin
					if (idx_q == echo_len_q) begin
						k_q     <= '0;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_ECHO_WR;
					end
				end
				ST_ECHO_WR: begin
					if (echo_skip || tx_st.push_ok) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_ECHO_RD;
					end
				end
				ST_RESP: begin
					if (k_q == resp_len) begin
						state_q <= ST_FLUSH;
					end else if (tx_st.push_ok) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (tx_st.finish_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// port pins are sampled with the parse request
	always_ff @(posedge clk) begin
		if (parse_go) begin
			pins_q <= item.port_pins;
		end
	end

	scio_tx_stage u_tx_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (tx_ctl),
		.levels       (levels_q),
		.boot         (boot_q),
		.status       (tx_st),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== sv/scio_rx_buf.sv =====
// receive store: byte memory with registered read port, fill count and first three bytes
// depends on scio_pkg
`timescale 1ns / 1ps

module scio_rx_buf import scio_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_go,
	input  logic [7:0]       wr_byte,
	input  logic             clr,
	input  logic             rd_en,
	input  logic [RX_AW-1:0] rd_addr,
	output logic [7:0]       rd_data,
	output rx_status_t       status
);

	logic [7:0]       store_mem [RX_DEPTH];
	logic [7:0]       rd_data_q;
	logic [RX_CW-1:0] count_q;
	logic [7:0]       hdr0_q, hdr1_q, hdr2_q;
	logic             wr_en;

	assign wr_en = wr_go && (count_q < RX_CW'(RX_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[count_q[RX_AW-1:0]] <= wr_byte;
		end
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	// command header copies, only trusted below the fill count
	always_ff @(posedge clk) begin
		if (wr_en && count_q == RX_CW'(0)) begin
			hdr0_q <= wr_byte;
		end
		if (wr_en && count_q == RX_CW'(1)) begin
			hdr1_q <= wr_byte;
		end
		if (wr_en && count_q == RX_CW'(2)) begin
			hdr2_q <= wr_byte;
		end
	end

	assign rd_data       = rd_data_q;
	assign status.count  = count_q;
	assign status.hdr0   = hdr0_q;
	assign status.hdr1   = hdr1_q;
	assign status.hdr2   = hdr2_q;

endmodule

// ===== sv/scio_ring.sv =====
// analog sample state: averaging ring memory with read-modify-write of the running sum
// depends on scio_pkg
`timescale 1ns / 1ps

module scio_ring import scio_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_go,
	input  logic               adc_channel,
	input  logic [ADC_W-1:0]   adc_value,
	output logic               busy,
	output logic [TOTAL_W-1:0] total,
	output logic [ADC_W-1:0]   latest
);

	logic [ADC_W-1:0]   ring_mem [AVG_DEPTH];
	logic [AVG_DEPTH-1:0] vld_q;
	logic [ADC_W-1:0]   rd_q;
	logic [AVG_AW-1:0]  slot_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADC_W-1:0]   latest_q;
	logic               go_s1;
	logic [ADC_W-1:0]   val_s1;
	logic               avg_go;
	logic [ADC_W-1:0]   old_val;

	assign avg_go  = sample_go && !adc_channel;
	// never-written slots count as zero
	assign old_val = vld_q[slot_q] ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1    <= 1'b0;
			vld_q    <= '0;
			slot_q   <= '0;
			total_q  <= '0;
			latest_q <= '0;
		end else begin
			go_s1 <= avg_go;
			if (sample_go && adc_channel) begin
				latest_q <= adc_value;
			end
			if (go_s1) begin
				total_q        <= total_q - TOTAL_W'(old_val) + TOTAL_W'(val_s1);
				vld_q[slot_q]  <= 1'b1;
				slot_q         <= (slot_q == AVG_AW'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (avg_go) begin
			rd_q   <= ring_mem[slot_q];
			val_s1 <= adc_value;
		end
		if (go_s1) begin
			ring_mem[slot_q] <= val_s1;
		end
	end

	assign busy   = go_s1;
	assign total  = total_q;
	assign latest = latest_q;

endmodule

// ===== sv/scio_tx_stage.sv =====
// transmit stage: one-character hold register ahead of the result register, so the
// final character can be flagged last; depends on scio_pkg
`timescale 1ns / 1ps

module scio_tx_stage import scio_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tx_ctl_t    ctl,
	input  logic [7:0] levels,
	input  logic       boot,
	output tx_status_t status,
	output logic       result_valid,
	input  logic       result_stall,
	output scio_out_t  result
);

	logic       pend_v_q;
	logic [7:0] pend_q;
	logic       out_v_q;
	scio_out_t  out_q;
	logic       out_free;
	logic       do_push;
	logic       do_fin;
	logic       load;

	assign out_free = !out_v_q || !result_stall;
	assign status.push_ok   = !pend_v_q || out_free;
	assign status.finish_ok = out_free;

	assign do_push = ctl.push && status.push_ok;
	assign do_fin  = ctl.finish && out_free;
	assign load    = (do_push && pend_v_q) || do_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (do_push) begin
				pend_v_q <= 1'b1;
			end else if (do_fin) begin
				pend_v_q <= 1'b0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			pend_q <= ctl.ch;
		end
		if (load) begin
			// finishing with nothing held gives the empty result
			out_q.tx_valid         <= do_fin ? pend_v_q : 1'b1;
			out_q.tx_byte          <= (do_fin && !pend_v_q) ? 8'h00 : pend_q;
			out_q.last             <= do_fin;
			out_q.discrete_outputs <= levels;
			out_q.boot_request     <= boot;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

// ===== sv/scio_checker.sv =====
// port-level checks of the serial command and i/o controller, bound to the top level
// depends on scio_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scio_checker import scio_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input scio_in_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input scio_out_t result
);

	// an empty result closes its parse and carries no character
	`ASSERT_SAME(a_empty_is_last, result_valid && !result.tx_valid,
		result.last && (result.tx_byte == 8'h00))

	// a parse request blocks intake on the next cycle
	`ASSERT_NEXT(a_parse_blocks, item_valid && !item_stall && (item.req_type == REQ_PARSE),
		item_stall)

	// a boot command always echoes its header, so its results carry characters
	`ASSERT_SAME(a_boot_has_chars, result_valid && result.boot_request, result.tx_valid)

	// a stalled result holds
	`ASSERT_NEXT(a_result_holds, result_valid && result_stall,
		result_valid && $stable(result))

endmodule

bind serial_command_io_controller scio_checker u_scio_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
